// ----- rtl/sscp_pkg.sv -----
// ----------------------------------------------------------------------------
// sscp_pkg
// shared constants for the segment closest points pipeline
// ----------------------------------------------------------------------------
package sscp_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS       = 32;
   localparam int DEGEN_EPS       = 4294;
   localparam int DIV_STAGES      = FRAC_BITS + 1;
   localparam int LATENCY         = 6 + DIV_STAGES + 3 + DIV_STAGES + 2;

endpackage

// ----- rtl/segment_segment_closest_points_top.sv -----
// ----------------------------------------------------------------------------
// segment_segment_closest_points_top
// closest points between two 3d segments, fully pipelined
// ----------------------------------------------------------------------------
// channel   | ports           | handshake
// request   | req_*           | start high, busy low
// response  | rsp_*           | rsp_strobe, one cycle, no back pressure
//
// one beat enters every cycle; busy stays low
// each beat passes through two 33-stage dividers on its way to the response
// synchronous reset clears the valid bits only
// the receiver cannot stall, so the pipeline never holds
module segment_segment_closest_points_top #(
   parameter int COORD_WIDTH = sscp_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_seg1_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg1_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg1_start_z,
   input  logic signed [COORD_WIDTH-1:0] req_seg1_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg1_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg1_end_z,
   input  logic signed [COORD_WIDTH-1:0] req_seg2_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg2_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg2_start_z,
   input  logic signed [COORD_WIDTH-1:0] req_seg2_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg2_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg2_end_z,
   output logic                          rsp_strobe,
   output logic signed [COORD_WIDTH-1:0] rsp_closest1_x,
   output logic signed [COORD_WIDTH-1:0] rsp_closest1_y,
   output logic signed [COORD_WIDTH-1:0] rsp_closest1_z,
   output logic signed [COORD_WIDTH-1:0] rsp_closest2_x,
   output logic signed [COORD_WIDTH-1:0] rsp_closest2_y,
   output logic signed [COORD_WIDTH-1:0] rsp_closest2_z
);
   import sscp_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;
   localparam int DT = 2 * W + 4;
   localparam int WW = 4 * W + 12;
   localparam int GW = 6 * W + 6 * DW;
   localparam int SA = 5 * DT + 2 + GW;
   localparam int SB = 33 + 33 + 1 + GW;
   localparam int PW = DW + 34;
   localparam int HB = DT / 2;
   localparam int HW = DT - HB;
   localparam int FO = SA - 1 - 2 * DT;

   function automatic logic signed [2*DW-1:0] dot_term(input logic signed [DW-1:0] a,
                                                       input logic signed [DW-1:0] b);
      return a * b;
   endfunction

   function automatic logic signed [PW-1:0] scale_term(input logic signed [DW-1:0] d,
                                                         input logic [32:0] frac);
      return d * $signed({1'b0, frac});
   endfunction

   assign busy = 1'b0;

   // stage 1: input capture
   logic                v1_ff;
   logic signed [W-1:0] p1_1_ff [0:2];
   logic signed [W-1:0] e1_1_ff [0:2];
   logic signed [W-1:0] p2_1_ff [0:2];
   logic signed [W-1:0] e2_1_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      p1_1_ff <= '{req_seg1_start_x, req_seg1_start_y, req_seg1_start_z};
      e1_1_ff <= '{req_seg1_end_x, req_seg1_end_y, req_seg1_end_z};
      p2_1_ff <= '{req_seg2_start_x, req_seg2_start_y, req_seg2_start_z};
      e2_1_ff <= '{req_seg2_end_x, req_seg2_end_y, req_seg2_end_z};
   end

   // stage 2: direction vectors
   logic                 v2_ff;
   logic signed [DW-1:0] d1_2_ff [0:2];
   logic signed [DW-1:0] d2_2_ff [0:2];
   logic signed [DW-1:0] r_2_ff  [0:2];
   logic [GW-1:0]        geo_2_in;
   logic [GW-1:0]        geo_2_ff;
   logic signed [DW-1:0] d1_2_in [0:2];
   logic signed [DW-1:0] d2_2_in [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d1_2_in[i] = DW'(e1_1_ff[i]) - DW'(p1_1_ff[i]);
         d2_2_in[i] = DW'(e2_1_ff[i]) - DW'(p2_1_ff[i]);
         geo_2_in[i*W +: W]             = p1_1_ff[i];
         geo_2_in[3*W + i*DW +: DW]     = d1_2_in[i];
         geo_2_in[3*W+3*DW + i*W +: W]  = p2_1_ff[i];
         geo_2_in[6*W+3*DW + i*DW +: DW] = d2_2_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      d1_2_ff  <= d1_2_in;
      d2_2_ff  <= d2_2_in;
      geo_2_ff <= geo_2_in;
      for (int i = 0; i < 3; i++) begin
         r_2_ff[i] <= DW'(p1_1_ff[i]) - DW'(p2_1_ff[i]);
      end
   end

   // stage 3: dot products
   logic                 v3_ff;
   logic signed [DT-1:0] l1_3_ff, l2_3_ff, f_3_ff, c_3_ff, b_3_ff;
   logic signed [DT-1:0] l1_3_in, l2_3_in, f_3_in, c_3_in, b_3_in;
   logic [GW-1:0]        geo_3_ff;

   always_comb begin
      l1_3_in = '0;
      l2_3_in = '0;
      f_3_in  = '0;
      c_3_in  = '0;
      b_3_in  = '0;
      for (int i = 0; i < 3; i++) begin
         l1_3_in = l1_3_in + DT'(dot_term(d1_2_ff[i], d1_2_ff[i]));
         l2_3_in = l2_3_in + DT'(dot_term(d2_2_ff[i], d2_2_ff[i]));
         f_3_in  = f_3_in  + DT'(dot_term(d2_2_ff[i], r_2_ff[i]));
         c_3_in  = c_3_in  + DT'(dot_term(d1_2_ff[i], r_2_ff[i]));
         b_3_in  = b_3_in  + DT'(dot_term(d1_2_ff[i], d2_2_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      l1_3_ff  <= l1_3_in;
      l2_3_ff  <= l2_3_in;
      f_3_ff   <= f_3_in;
      c_3_ff   <= c_3_in;
      b_3_ff   <= b_3_in;
      geo_3_ff <= geo_2_ff;
   end

   // stage 4: partial products of the wide terms
   logic                   v4p_ff;
   logic signed [DT-1:0]   ma_4p_in [0:3];
   logic signed [DT-1:0]   mb_4p_in [0:3];
   logic signed [2*HW-1:0] hh_4p_ff [0:3];
   logic signed [HW+HB:0]  hl_4p_ff [0:3];
   logic signed [HW+HB:0]  lh_4p_ff [0:3];
   logic [2*HB-1:0]        ll_4p_ff [0:3];
   logic signed [DT-1:0]   l1_4p_ff, l2_4p_ff, f_4p_ff, c_4p_ff, b_4p_ff;
   logic [GW-1:0]          geo_4p_ff;

   always_comb begin
      ma_4p_in[0] = l1_3_ff;
      mb_4p_in[0] = l2_3_ff;
      ma_4p_in[1] = b_3_ff;
      mb_4p_in[1] = b_3_ff;
      ma_4p_in[2] = b_3_ff;
      mb_4p_in[2] = f_3_ff;
      ma_4p_in[3] = c_3_ff;
      mb_4p_in[3] = l2_3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4p_ff <= 1'b0;
      end else begin
         v4p_ff <= v3_ff;
      end
      for (int j = 0; j < 4; j++) begin
         hh_4p_ff[j] <= $signed(ma_4p_in[j][DT-1:HB]) * $signed(mb_4p_in[j][DT-1:HB]);
         hl_4p_ff[j] <= $signed(ma_4p_in[j][DT-1:HB]) *
                        $signed({1'b0, mb_4p_in[j][HB-1:0]});
         lh_4p_ff[j] <= $signed({1'b0, ma_4p_in[j][HB-1:0]}) *
                        $signed(mb_4p_in[j][DT-1:HB]);
         ll_4p_ff[j] <= ma_4p_in[j][HB-1:0] * mb_4p_in[j][HB-1:0];
      end
      l1_4p_ff  <= l1_3_ff;
      l2_4p_ff  <= l2_3_ff;
      f_4p_ff   <= f_3_ff;
      c_4p_ff   <= c_3_ff;
      b_4p_ff   <= b_3_ff;
      geo_4p_ff <= geo_3_ff;
   end

   // stage 5: wide product sums and point tests
   logic                 v4_ff;
   logic                 pt1_4_ff, pt2_4_ff;
   logic signed [WW-1:0] l1l2_4_ff, bb_4_ff, bf_4_ff, cl2_4_ff;
   logic signed [DT-1:0] l1_4_ff, l2_4_ff, f_4_ff, c_4_ff, b_4_ff;
   logic [GW-1:0]        geo_4_ff;
   logic signed [WW-1:0] prod_4_in [0:3];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         prod_4_in[j] = (WW'(hh_4p_ff[j]) <<< (2 * HB)) + (WW'(hl_4p_ff[j]) <<< HB)
                      + (WW'(lh_4p_ff[j]) <<< HB) + $signed(WW'(ll_4p_ff[j]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v4p_ff;
      end
      pt1_4_ff  <= l1_4p_ff <= DT'(DEGEN_EPS);
      pt2_4_ff  <= l2_4p_ff <= DT'(DEGEN_EPS);
      l1l2_4_ff <= prod_4_in[0];
      bb_4_ff   <= prod_4_in[1];
      bf_4_ff   <= prod_4_in[2];
      cl2_4_ff  <= prod_4_in[3];
      l1_4_ff   <= l1_4p_ff;
      l2_4_ff   <= l2_4p_ff;
      f_4_ff    <= f_4p_ff;
      c_4_ff    <= c_4p_ff;
      b_4_ff    <= b_4p_ff;
      geo_4_ff  <= geo_4p_ff;
   end

   // stage 6: first ratio operands
   logic                 v5_ff;
   logic signed [WW-1:0] num_5_ff, den_5_ff;
   logic [SA-1:0]        side_5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      num_5_ff <= bf_4_ff - cl2_4_ff;
      den_5_ff <= (pt1_4_ff || pt2_4_ff) ? '0 : l1l2_4_ff - bb_4_ff;
      side_5_ff <= {b_4_ff, c_4_ff, f_4_ff, l1_4_ff, l2_4_ff, pt1_4_ff, pt2_4_ff,
                    geo_4_ff};
   end

   logic          va_out;
   logic [32:0]   qa_out;
   logic [SA-1:0] sa_out;

   sscp_div #(.NW(WW), .SW(SA)) u_div_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_num    (num_5_ff),
      .in_den    (den_5_ff),
      .in_side   (side_5_ff),
      .out_valid (va_out),
      .out_quo   (qa_out),
      .out_side  (sa_out)
   );

   logic signed [DT-1:0] b_a;

   assign b_a = sa_out[SA-1 -: DT];

   // t numerator partial products
   logic                   v6p_ff;
   logic signed [HW+33:0]  bhs_6p_ff;
   logic [HB+32:0]         bls_6p_ff;
   logic [32:0]            s0_6p_ff;
   logic [SA-1:0]          side_6p_ff;
   logic signed [DT-1:0]   f_p;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6p_ff <= 1'b0;
      end else begin
         v6p_ff <= va_out;
      end
      bhs_6p_ff  <= $signed(b_a[DT-1:HB]) * $signed({1'b0, qa_out});
      bls_6p_ff  <= b_a[HB-1:0] * qa_out;
      s0_6p_ff   <= qa_out;
      side_6p_ff <= sa_out;
   end

   assign f_p = side_6p_ff[FO -: DT];

   // t numerator
   logic                 v6_ff;
   logic signed [WW-1:0] tn_6_ff;
   logic [32:0]          s0_6_ff;
   logic [SA-1:0]        side_6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v6p_ff;
      end
      tn_6_ff   <= (WW'(bhs_6p_ff) <<< HB) + $signed(WW'(bls_6p_ff)) + (WW'(f_p) <<< 32);
      s0_6_ff   <= s0_6p_ff;
      side_6_ff <= side_6p_ff;
   end

   logic signed [DT-1:0] b_6, c_6, f_6, l1_6, l2_6;
   logic                 pt1_6, pt2_6;
   logic [GW-1:0]        geo_6;
   logic signed [WW-1:0] l2s_6;

   assign {b_6, c_6, f_6, l1_6, l2_6, pt1_6, pt2_6, geo_6} = side_6_ff;
   assign l2s_6 = WW'(l2_6) <<< 32;

   // case selection for the second ratio
   logic                 v7_ff;
   logic signed [WW-1:0] num_7_in, den_7_in, num_7_ff, den_7_ff;
   logic [32:0]          sf_7_in, tf_7_in;
   logic                 qt_7_in;
   logic [SB-1:0]        side_7_ff;

   always_comb begin
      sf_7_in = '0;
      tf_7_in = '0;
      qt_7_in = 1'b0;
      num_7_in = -WW'(c_6);
      den_7_in = WW'(l1_6);
      if (pt1_6 && pt2_6) begin
         qt_7_in  = 1'b1;
         num_7_in = '0;
      end else if (pt1_6) begin
         qt_7_in  = 1'b1;
         num_7_in = WW'(f_6);
         den_7_in = WW'(l2_6);
      end else if (pt2_6) begin
         qt_7_in = 1'b0;
      end else if (tn_6_ff < 0) begin
         qt_7_in = 1'b0;
      end else if (tn_6_ff > l2s_6) begin
         tf_7_in  = 33'h1_0000_0000;
         num_7_in = WW'(b_6) - WW'(c_6);
      end else begin
         qt_7_in  = 1'b1;
         sf_7_in  = s0_6_ff;
         num_7_in = tn_6_ff;
         den_7_in = l2s_6;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff;
      end
      num_7_ff  <= num_7_in;
      den_7_ff  <= den_7_in;
      side_7_ff <= {sf_7_in, tf_7_in, qt_7_in, geo_6};
   end

   logic          vb_out;
   logic [32:0]   qb_out;
   logic [SB-1:0] sb_out;

   sscp_div #(.NW(WW), .SW(SB)) u_div_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v7_ff),
      .in_num    (num_7_ff),
      .in_den    (den_7_ff),
      .in_side   (side_7_ff),
      .out_valid (vb_out),
      .out_quo   (qb_out),
      .out_side  (sb_out)
   );

   logic [32:0]   sf_b, tf_b, s_b, t_b;
   logic          qt_b;
   logic [GW-1:0] geo_b;

   assign {sf_b, tf_b, qt_b, geo_b} = sb_out;
   assign s_b = qt_b ? sf_b : qb_out;
   assign t_b = qt_b ? qb_out : tf_b;

   // interpolation products
   logic                 v8_ff;
   logic signed [PW-1:0] prod_8_ff  [0:5];
   logic signed [W-1:0]  start_8_ff [0:5];

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else begin
         v8_ff <= vb_out;
      end
      for (int i = 0; i < 3; i++) begin
         prod_8_ff[i]    <= scale_term(geo_b[3*W + i*DW +: DW], s_b);
         prod_8_ff[3+i]  <= scale_term(geo_b[6*W+3*DW + i*DW +: DW], t_b);
         start_8_ff[i]   <= $signed(geo_b[i*W +: W]);
         start_8_ff[3+i] <= $signed(geo_b[3*W+3*DW + i*W +: W]);
      end
   end

   // round, offset and saturate
   logic                      v9_ff;
   logic signed [W-1:0]       out_9_ff [0:5];
   logic signed [PW-1:0]      rnd_9_in [0:5];
   logic signed [PW-33+1-1:0] sum_9_in [0:5];
   logic signed [W-1:0]       out_9_in [0:5];

   localparam int SUMW = PW - 32;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         rnd_9_in[i] = (prod_8_ff[i] + PW'(64'sd2147483648)) >>> 32;
         sum_9_in[i] = SUMW'(rnd_9_in[i]) + SUMW'(start_8_ff[i]);
         if (sum_9_in[i] > $signed(SUMW'({1'b0, {(W-1){1'b1}}}))) begin
            out_9_in[i] = {1'b0, {(W-1){1'b1}}};
         end else if (sum_9_in[i] < -$signed(SUMW'({1'b0, {(W-1){1'b1}}})) - SUMW'(1))
         begin
            out_9_in[i] = {1'b1, {(W-1){1'b0}}};
         end else begin
            out_9_in[i] = sum_9_in[i][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else begin
         v9_ff <= v8_ff;
      end
      out_9_ff <= out_9_in;
   end

   assign rsp_strobe     = v9_ff;
   assign rsp_closest1_x = out_9_ff[0];
   assign rsp_closest1_y = out_9_ff[1];
   assign rsp_closest1_z = out_9_ff[2];
   assign rsp_closest2_x = out_9_ff[3];
   assign rsp_closest2_y = out_9_ff[4];
   assign rsp_closest2_z = out_9_ff[5];

endmodule

// ----- rtl/sscp_div.sv -----
// ----------------------------------------------------------------------------
// sscp_div
// pipelined clamped ratio num/den in [0,1], one quotient bit per stage
// ----------------------------------------------------------------------------
module sscp_div #(
   parameter int NW = 140,
   parameter int SW = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [NW-1:0] in_num,
   input  logic signed [NW-1:0] in_den,
   input  logic [SW-1:0]        in_side,
   output logic                 out_valid,
   output logic [32:0]          out_quo,
   output logic [SW-1:0]        out_side
);
   import sscp_pkg::*;

   localparam int N = FRAC_BITS;

   logic          valid_ff [0:N];
   logic          done_ff  [0:N];
   logic [NW:0]   rem_ff   [0:N];
   logic [NW-1:0] den_ff   [0:N];
   logic [32:0]   quo_ff   [0:N];
   logic [SW-1:0] side_ff  [0:N];

   logic zero_in, one_in;

   always_comb begin
      zero_in = (in_den <= 0) || (in_num <= 0);
      one_in  = !zero_in && (in_num >= in_den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      done_ff[0] <= zero_in || one_in;
      rem_ff[0]  <= {1'b0, in_num};
      den_ff[0]  <= in_den;
      quo_ff[0]  <= one_in ? 33'h1_0000_0000 : 33'd0;
      side_ff[0] <= in_side;
   end

   for (genvar k = 1; k <= N; k++) begin : g_stage
      logic [NW:0] dbl_in;
      logic        ge_in;
      always_comb begin
         dbl_in = {rem_ff[k-1][NW-1:0], 1'b0};
         ge_in  = dbl_in >= {1'b0, den_ff[k-1]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_ff[k-1];
         end
         done_ff[k] <= done_ff[k-1];
         den_ff[k]  <= den_ff[k-1];
         side_ff[k] <= side_ff[k-1];
         if (done_ff[k-1]) begin
            rem_ff[k] <= rem_ff[k-1];
            quo_ff[k] <= quo_ff[k-1];
         end else begin
            rem_ff[k] <= ge_in ? dbl_in - {1'b0, den_ff[k-1]} : dbl_in;
            quo_ff[k] <= {quo_ff[k-1][31:0], ge_in};
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign out_quo   = quo_ff[N];
   assign out_side  = side_ff[N];

endmodule

// ----- rtl/sscp_checker.sv -----
// ----------------------------------------------------------------------------
// sscp_checker
// port level checks for the segment closest points block
// ----------------------------------------------------------------------------
module sscp_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);
   import sscp_pkg::*;

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_strobe_has_beat : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("response without request beat");

   a_quiet_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("response right after reset");

endmodule

bind segment_segment_closest_points_top sscp_checker u_sscp_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

// ----- sim/segment_segment_closest_points_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_segment_closest_points_top_test
// checks the closest points between two 3d segments against a wide-integer
// predictor; directed corner beats then random segment pairs sent in bursts
// ----------------------------------------------------------------------------
module segment_segment_closest_points_top_test;

   localparam int CW = sscp_pkg::COORD_WIDTH_DEF;
   localparam int WATCHDOG = 20000;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [255:0] big_type;
   typedef struct {
      coord_type v[12];
   } seg_pair_type;
   typedef struct {
      coord_type v[6];
   } points_type;

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   coord_type req_v[12];
   logic      rsp_strobe;
   coord_type rsp_v[6];

   seg_pair_type pending_pairs[$];
   points_type   expected_points[$];
   int           fail_count;
   int           idle_cycles;
   int           burst_left;
   int           gap_left;
   bit           stim_done;

   segment_segment_closest_points_top #(.COORD_WIDTH(CW)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_seg1_start_x(req_v[0]), .req_seg1_start_y(req_v[1]),
      .req_seg1_start_z(req_v[2]), .req_seg1_end_x(req_v[3]),
      .req_seg1_end_y(req_v[4]), .req_seg1_end_z(req_v[5]),
      .req_seg2_start_x(req_v[6]), .req_seg2_start_y(req_v[7]),
      .req_seg2_start_z(req_v[8]), .req_seg2_end_x(req_v[9]),
      .req_seg2_end_y(req_v[10]), .req_seg2_end_z(req_v[11]),
      .rsp_strobe(rsp_strobe),
      .rsp_closest1_x(rsp_v[0]), .rsp_closest1_y(rsp_v[1]),
      .rsp_closest1_z(rsp_v[2]), .rsp_closest2_x(rsp_v[3]),
      .rsp_closest2_y(rsp_v[4]), .rsp_closest2_z(rsp_v[5])
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // clamped quotient, 32 fraction bits, in [0, 2^32]
   function automatic logic [32:0] clamped_fraction(big_type num, big_type den);
      big_type rem;
      logic [32:0] q;
      rem = num;
      q = '0;
      if (den <= 0 || num <= 0) return 33'd0;
      if (num >= den) return 33'h1_0000_0000;
      for (int i = 0; i < 32; i++) begin
         rem = rem <<< 1;
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic coord_type lerp_coord(big_type p, big_type d, logic [32:0] frac);
      big_type acc;
      big_type cmax;
      big_type cmin;
      cmax = (big_type'(1) <<< (CW - 1)) - 1;
      cmin = -cmax - 1;
      acc = d * $signed({223'd0, frac});
      acc = ((acc + (big_type'(1) <<< 31)) >>> 32) + p;
      if (acc > cmax) return coord_type'(cmax);
      if (acc < cmin) return coord_type'(cmin);
      return coord_type'(acc);
   endfunction

   function automatic points_type closest_points(seg_pair_type pr);
      big_type p1[3], p2[3], d1[3], d2[3], r[3];
      big_type l1, l2, f, c, b, dn, tn, l2s;
      logic [32:0] s, t;
      bit pt1, pt2;
      points_type res;
      l1 = 0; l2 = 0; f = 0; c = 0; b = 0;
      s = '0; t = '0;
      for (int i = 0; i < 3; i++) begin
         p1[i] = big_type'(pr.v[i]);
         d1[i] = big_type'(pr.v[3+i]) - p1[i];
         p2[i] = big_type'(pr.v[6+i]);
         d2[i] = big_type'(pr.v[9+i]) - p2[i];
         r[i]  = p1[i] - p2[i];
         l1 += d1[i] * d1[i];
         l2 += d2[i] * d2[i];
         f  += d2[i] * r[i];
         c  += d1[i] * r[i];
         b  += d1[i] * d2[i];
      end
      pt1 = l1 <= sscp_pkg::DEGEN_EPS;
      pt2 = l2 <= sscp_pkg::DEGEN_EPS;
      if (pt1 && pt2) begin
         s = '0;
      end else if (pt1) begin
         t = clamped_fraction(f, l2);
      end else if (pt2) begin
         s = clamped_fraction(-c, l1);
      end else begin
         dn = l1 * l2 - b * b;
         s = (dn != 0) ? clamped_fraction(b * f - c * l2, dn) : 33'd0;
         tn = b * $signed({223'd0, s}) + (f <<< 32);
         l2s = l2 <<< 32;
         if (tn < 0) begin
            t = '0;
            s = clamped_fraction(-c, l1);
         end else if (tn > l2s) begin
            t = 33'h1_0000_0000;
            s = clamped_fraction(b - c, l1);
         end else begin
            t = clamped_fraction(tn, l2s);
         end
      end
      for (int i = 0; i < 3; i++) begin
         res.v[i]   = lerp_coord(p1[i], d1[i], s);
         res.v[3+i] = lerp_coord(p2[i], d2[i], t);
      end
      return res;
   endfunction

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
         2: return coord_type'($signed($urandom_range(0, 32'h0000_03FF)) - 32'sh0000_0200);
         default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      endcase
   endfunction

   task automatic queue_pair(coord_type a[12]);
      seg_pair_type pr;
      for (int i = 0; i < 12; i++) pr.v[i] = a[i];
      pending_pairs = {pending_pairs, pr};
   endtask

   initial begin
      coord_type a[12];
      int mode;
      coord_type base;
      coord_type dir[3];
      // extremes
      foreach (a[i]) a[i] = 32'sh7FFF_FFFF;
      queue_pair(a);
      foreach (a[i]) a[i] = 32'sh8000_0000;
      queue_pair(a);
      foreach (a[i]) a[i] = (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      queue_pair(a);
      foreach (a[i]) a[i] = (i < 6) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      queue_pair(a);
      foreach (a[i]) a[i] = ((i % 6) < 3) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      queue_pair(a);
      // both segments points
      foreach (a[i]) a[i] = 0;
      queue_pair(a);
      foreach (a[i]) a[i] = (i < 6) ? 32'sh0001_0000 : -32'sh0002_0000;
      queue_pair(a);
      // first a point, second a point, near-degenerate lengths
      a = '{0, 0, 0, 0, 0, 0, -65536, 5, 0, 65536, 5, 0};
      queue_pair(a);
      a = '{-65536, 5, 0, 65536, 5, 0, 7, 7, 7, 7, 7, 7};
      queue_pair(a);
      a = '{0, 0, 0, 65, 10, 0, 3, 3, 3, 66, 3, 3};
      queue_pair(a);
      a = '{0, 0, 0, 65, 10, 1, 0, 0, 0, 65, 10, 1};
      queue_pair(a);
      // parallel, overlapping and disjoint
      a = '{0, 0, 0, 65536, 0, 0, 32768, 65536, 0, 98304, 65536, 0};
      queue_pair(a);
      a = '{0, 0, 0, 65536, 0, 0, -196608, 65536, 0, -131072, 65536, 0};
      queue_pair(a);
      a = '{0, 0, 0, 65536, 0, 0, 262144, 0, 0, 196608, 0, 0};
      queue_pair(a);
      // crossing, t below zero, t above one
      a = '{-65536, 0, 0, 65536, 0, 0, 0, -65536, 65536, 0, 65536, 65536};
      queue_pair(a);
      a = '{0, 0, 0, 65536, 0, 0, 200000, 65536, 0, 200000, 300000, 0};
      queue_pair(a);
      a = '{0, 0, 0, 65536, 0, 0, -200000, -300000, 0, -200000, -65536, 0};
      queue_pair(a);
      a = '{0, 0, 0, 65536, 65536, 0, 131072, 0, 0, 131072, 65536, 65536};
      queue_pair(a);
      for (int k = 0; k < 900; k++) begin
         mode = $urandom_range(0, 9);
         if (mode < 2) begin
            foreach (a[i]) a[i] = rand_coord($urandom_range(0, 3));
         end else if (mode < 4) begin
            // parallel or collinear pair
            foreach (dir[i]) dir[i] = rand_coord(1);
            for (int i = 0; i < 3; i++) begin
               base = rand_coord(1);
               a[i] = base;
               a[3+i] = base + dir[i];
               a[6+i] = base + rand_coord(2);
               a[9+i] = a[6+i] - (($urandom_range(0, 1)) ? dir[i] : dir[i] >>> 1);
            end
         end else if (mode < 5) begin
            // one segment degenerate when every axis picks it, never both
            foreach (a[i]) a[i] = rand_coord(1);
            for (int i = 0; i < 3; i++) begin
               if ($urandom_range(0, 1)) a[3+i] = a[i] + coord_type'($urandom_range(0, 30));
               else a[9+i] = a[6+i] + coord_type'($urandom_range(0, 30));
            end
         end else begin
            foreach (a[i]) a[i] = rand_coord(mode < 8 ? 1 : 2);
         end
         queue_pair(a);
      end
      stim_done = 1'b1;
   end

   // driver, bursts and gaps
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) void'(pending_pairs.pop_front());
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_pairs.size() > ((start && !busy) ? 0 : 0)) begin
            start <= 1'b1;
            for (int i = 0; i < 12; i++) req_v[i] <= pending_pairs[0].v[i];
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      points_type exp_pts;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (start && !busy) begin
            seg_pair_type pr;
            for (int i = 0; i < 12; i++) pr.v[i] = req_v[i];
            expected_points = {expected_points, closest_points(pr)};
         end
         if (rsp_strobe) begin
            if (expected_points.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count++;
            end else begin
               exp_pts = expected_points.pop_front();
               for (int i = 0; i < 6; i++) begin
                  if (rsp_v[i] !== exp_pts.v[i]) begin
                     $error("closest%0d_%s expected %0d got %0d", i / 3 + 1,
                            (i % 3 == 0) ? "x" : (i % 3 == 1) ? "y" : "z",
                            exp_pts.v[i], rsp_v[i]);
                     fail_count++;
                  end
               end
            end
         end
         idle_cycles <= ((start && !busy) || rsp_strobe) ? 0 : idle_cycles + 1;
      end
   end

   initial begin
      fail_count = 0;
      burst_left = 0;
      gap_left = 0;
      reset = 1'b1;
      start = 1'b0;
      foreach (req_v[i]) req_v[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (!(stim_done && pending_pairs.size() == 0 && !start
               && expected_points.size() == 0) && idle_cycles < WATCHDOG)
         @(posedge clock);
      if (idle_cycles >= WATCHDOG) begin
         $display("Simulation FAILED");
      end else begin
         repeat (sscp_pkg::LATENCY + 10) @(posedge clock);
         if (fail_count == 0 && expected_points.size() == 0)
            $display("Simulation PASSED");
         else
            $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/sscp_pkg.sv
rtl/sscp_div.sv
rtl/segment_segment_closest_points_top.sv
rtl/sscp_checker.sv
sim/segment_segment_closest_points_top_test.sv
